[hdl/tpsw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsw_pkg: shared constants and types of the split-window normalizer
// Widths of the window arithmetic, register reset values, register indexes
// and the result bundle of the iterative divider.
// ----------------------------------------------------------------------------
package tpsw_pkg;

  // Window and row limits.
  localparam int unsigned MAX_HALF_WIDTH = 32;
  localparam int unsigned MAX_BINS       = 4096;
  localparam int unsigned RING_DEPTH     = 128;
  localparam int unsigned RING_AW        = $clog2(RING_DEPTH);
  localparam int unsigned MAX_RESULTS    = MAX_HALF_WIDTH + 1;

  // Field and register widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BIN_W    = 12;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned HW_W     = 6;
  localparam int unsigned CLIP_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RESULTS + 1);

  // Stream data widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - BIN_W - SAMPLE_W;

  // Window statistics: up to two segments of MAX_HALF_WIDTH+1 bins each.
  localparam int unsigned N_W    = $clog2(2 * MAX_RESULTS + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + N_W;
  localparam int unsigned NN_W   = 2 * N_W;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned NUM_W  = SAMPLE_W + FRAC_W + NN_W;
  localparam int unsigned DEN_W  = SUM_W + N_W + 1;
  localparam int unsigned CLIPS_W = CLIP_W + SUM_W;
  localparam int unsigned CLIP_FRAC_W = 12;

  // Shared multiplier operands and product.
  localparam int unsigned MUL_W  = SUM_W;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Divider: 16 quotient bits plus one step for the saturation test.
  localparam int unsigned QUOT_W = 16;
  localparam int unsigned DSR_W  = DEN_W + QUOT_W;
  localparam int unsigned DSTEP_W = $clog2(QUOT_W + 1);

  // Result constants in Q8.8.
  localparam logic [QUOT_W-1:0] Q_ONE = QUOT_W'(256);
  localparam logic [QUOT_W-1:0] Q_MAX = '1;

  // Register reset values.
  localparam logic [HW_W-1:0]   OUTER_RST = HW_W'(16);
  localparam logic [HW_W-1:0]   GAP_RST   = HW_W'(2);
  localparam logic [CLIP_W-1:0] CLIP_RST  = CLIP_W'(6144);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTER = 2'd0,
    CFG_GAP   = 2'd1,
    CFG_CLIP  = 2'd2
  } cfg_idx_e;

  // Result of one division.
  typedef struct packed {
    logic              done;
    logic              sat;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage : tpsw_pkg
`default_nettype wire

[hdl/tpsw_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsw_mul: shared unsigned multiplier
// One registered product per cycle; the sequencer steers both operands.
// ----------------------------------------------------------------------------
module tpsw_mul (
  input  wire                          clk_i,
  input  wire  [tpsw_pkg::MUL_W-1:0]   a_i,
  input  wire  [tpsw_pkg::MUL_W-1:0]   b_i,
  output logic [tpsw_pkg::PROD_W-1:0]  p_o
);
  import tpsw_pkg::*;

  logic [PROD_W-1:0] p_q;

  // Product register, loaded in the cycle after the operands.
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule : tpsw_mul
`default_nettype wire

[hdl/tpsw_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsw_div: iterative restoring divider with saturation
// First step tests the quotient against 2^16, then one quotient bit per
// cycle from the top down. A done pulse carries the result.
// ----------------------------------------------------------------------------
module tpsw_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [tpsw_pkg::NUM_W-1:0]   num_i,
  input  wire  [tpsw_pkg::DEN_W-1:0]   den_i,
  output tpsw_pkg::div_res_t           res_o
);
  import tpsw_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic               sat_q;
  logic [DSTEP_W-1:0] step_q;
  logic [NUM_W-1:0]   rem_q;
  logic [DSR_W-1:0]   dsr_q;
  logic [QUOT_W-1:0]  quot_q;
  logic               ge;

  // Trial compare of the remainder against the shifted divisor.
  assign ge = DSR_W'(rem_q) >= dsr_q;

  // Step sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        sat_q  <= 1'b0;
        step_q <= DSTEP_W'(QUOT_W);
        rem_q  <= num_i;
        dsr_q  <= {den_i, {QUOT_W{1'b0}}};
        quot_q <= '0;
      end else if (busy_q) begin
        if (step_q == DSTEP_W'(QUOT_W)) begin
          // Quotient of 2^16 or more saturates at once.
          if (ge) begin
            sat_q  <= 1'b1;
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            dsr_q  <= dsr_q >> 1;
            step_q <= step_q - 1'b1;
          end
        end else begin
          if (ge) begin
            rem_q <= rem_q - dsr_q[NUM_W-1:0];
            quot_q[step_q[$clog2(QUOT_W)-1:0]] <= 1'b1;
          end
          if (step_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            dsr_q  <= dsr_q >> 1;
            step_q <= step_q - 1'b1;
          end
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.quot = quot_q;

endmodule : tpsw_div
`default_nettype wire

[hdl/tpsw_spectrum_normalizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsw_spectrum_normalizer: two-pass split-window spectrum normalizer
// Bins of a row stream in; each bin is divided by a clipped background mean
// taken over the window on both sides of it, giving a Q8.8 ratio.
// ----------------------------------------------------------------------------
//   Port group   Dir  Transfer rule         Content
//   s_axis_*     in   tvalid & tready       one bin sample, tlast ends row
//   m_axis_*     out  tvalid & tready       normalized bin, tuser = saturated
//   cfg_*        in   cfg_we_i high         register write, no read-back
//
// An input transfer writes the bin into the ring memory and then releases up
// to 33 results. Each result takes two walks over its window of at most 66
// bins through the ring's single read port, five products in the shared
// multiplier besides one per bin of the second walk, and 17 steps of the
// divider. An empty window skips the walks, the products and the divider.
// The input is ready only while the sequencer is idle; a full output register
// holds the sequencer until its transfer. Reset clears the row counters and
// loads the register defaults; the ring needs no clearing.
// ----------------------------------------------------------------------------
module tpsw_spectrum_normalizer (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Input stream: tdata[15:0] sample
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [tpsw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire                                s_axis_tlast,
  // Output stream: tdata[11:0] bin_index, [27:12] normalized, [31:28] zero
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [tpsw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Output flag: tuser[0] saturated
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  // Configuration write port
  input  wire                                cfg_we_i,
  input  wire  [tpsw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [tpsw_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import tpsw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_RANGE,
    ST_KCAP,
    ST_PASS1,
    ST_CLIPMUL,
    ST_CLIPCAP,
    ST_PASS2,
    ST_PRODS,
    ST_DIVSTART,
    ST_DIVWAIT,
    ST_OUT
  } state_e;

  // Configuration registers.
  logic [HW_W-1:0]   outer_q;
  logic [HW_W-1:0]   gap_q;
  logic [CLIP_W-1:0] clip_q;

  // Sequencer and row state.
  state_e               state_q;
  logic [CNT_W-1:0]     rc_q;
  logic [CNT_W-1:0]     emit_q;
  logic [RES_CNT_W-1:0] cnt_q;
  logic                 last_q;

  // Window edges and walk.
  logic [CNT_W-1:0] ls_q, le_q, rs_q, re_q;
  logic [CNT_W-1:0] lo0_q, hi0_q, lo1_q, hi1_q;
  logic             two_q;
  logic             empty_q;
  logic [CNT_W-1:0] widx_q;
  logic             wseg_q;
  logic             wend_q;
  logic             rv1_q;
  logic             rv2_q;

  // Window statistics.
  logic [SAMPLE_W-1:0] samp_k_q;
  logic [SUM_W-1:0]    sum_q;
  logic [N_W-1:0]      n_q;
  logic [CLIPS_W-1:0]  clip_s_q;
  logic [SUM_W-1:0]    kept_q;
  logic [N_W-1:0]      nclip_q;
  logic [SAMPLE_W-1:0] x_q;
  logic [NN_W-1:0]     nn_q;
  logic [DEN_W-1:0]    den_q;
  logic [NUM_W-1:0]    num_q;
  logic [2:0]          mstep_q;
  logic [QUOT_W-1:0]   quot_q;
  logic                sat_q;

  // Output register.
  logic                out_vld_q;
  logic [BIN_W-1:0]    out_bin_q;
  logic [QUOT_W-1:0]   out_norm_q;
  logic                out_sat_q;
  logic                out_last_q;

  // Ring memory.
  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [RING_AW-1:0]  rd_addr;
  logic                in_xfer;

  // Shared units.
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic              div_start;
  div_res_t          div_res;

  // Combinational helpers.
  logic [HW_W-1:0]  g_eff, e_eff;
  logic [CNT_W-1:0] g_c, e_c, len_m1, pend, rc_inc;
  logic [CNT_W:0]   kpe, kpg;
  logic             emit_go;
  logic             walk_state;
  logic             walk_issue;
  logic [CNT_W-1:0] whi;
  logic             out_free;

  // Clamp the window registers to their working ranges.
  always_comb begin
    if (outer_q == '0) begin
      g_eff = HW_W'(1);
    end else if (outer_q > HW_W'(MAX_HALF_WIDTH)) begin
      g_eff = HW_W'(MAX_HALF_WIDTH);
    end else begin
      g_eff = outer_q;
    end
    if (gap_q > HW_W'(MAX_HALF_WIDTH)) begin
      e_eff = HW_W'(MAX_HALF_WIDTH);
    end else begin
      e_eff = gap_q;
    end
  end

  assign g_c    = CNT_W'(g_eff);
  assign e_c    = CNT_W'(e_eff);
  assign len_m1 = rc_q - 1'b1;
  assign pend   = rc_q - emit_q;
  assign rc_inc = rc_q + 1'b1;
  assign kpe    = {1'b0, emit_q} + {1'b0, e_c};
  assign kpg    = {1'b0, emit_q} + {1'b0, g_c};

  // A bin is released once G later bins are in, or at the row end.
  assign emit_go = (cnt_q < RES_CNT_W'(MAX_RESULTS)) && (emit_q < rc_q) &&
                   (last_q || (pend > g_c));

  // Walk over the window segments, one ring read per cycle.
  assign walk_state = (state_q == ST_PASS1) || (state_q == ST_PASS2);
  assign walk_issue = walk_state && !wend_q;
  assign whi        = wseg_q ? hi1_q : hi0_q;
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_vld_q || m_axis_tready;

  always_comb begin
    if (walk_issue) begin
      rd_addr = widx_q[RING_AW-1:0];
    end else begin
      rd_addr = emit_q[RING_AW-1:0];
    end
  end

  // Ring memory: written on input transfers, read every cycle.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ring_mem[rc_q[RING_AW-1:0]] <= s_axis_tdata[SAMPLE_W-1:0];
    end
    rdata_q <= ring_mem[rd_addr];
  end

  // Operand steering for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CLIPMUL: begin
        mul_a = MUL_W'(clip_q);
        mul_b = sum_q;
      end
      ST_PASS2: begin
        mul_a = MUL_W'(rdata_q);
        mul_b = MUL_W'(n_q);
      end
      ST_PRODS: begin
        case (mstep_q)
          3'd0: begin
            mul_a = MUL_W'(n_q);
            mul_b = MUL_W'(n_q);
          end
          3'd1: begin
            mul_a = kept_q;
            mul_b = MUL_W'(n_q);
          end
          3'd2: begin
            mul_a = MUL_W'(nclip_q);
            mul_b = sum_q;
          end
          3'd3: begin
            mul_a = MUL_W'(samp_k_q);
            mul_b = MUL_W'(nn_q);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tpsw_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign div_start = (state_q == ST_DIVSTART);

  tpsw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .res_o   (div_res)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= OUTER_RST;
      gap_q   <= GAP_RST;
      clip_q  <= CLIP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OUTER: outer_q <= cfg_wdata_i[HW_W-1:0];
        CFG_GAP:   gap_q   <= cfg_wdata_i[HW_W-1:0];
        CFG_CLIP:  clip_q  <= cfg_wdata_i[CLIP_W-1:0];
        default:   ;
      endcase
    end
  end

  // Sequencer with its working and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rc_q       <= '0;
      emit_q     <= '0;
      cnt_q      <= '0;
      last_q     <= 1'b0;
      ls_q       <= '0;
      le_q       <= '0;
      rs_q       <= '0;
      re_q       <= '0;
      lo0_q      <= '0;
      hi0_q      <= '0;
      lo1_q      <= '0;
      hi1_q      <= '0;
      two_q      <= 1'b0;
      empty_q    <= 1'b0;
      widx_q     <= '0;
      wseg_q     <= 1'b0;
      wend_q     <= 1'b0;
      rv1_q      <= 1'b0;
      rv2_q      <= 1'b0;
      samp_k_q   <= '0;
      sum_q      <= '0;
      n_q        <= '0;
      clip_s_q   <= '0;
      kept_q     <= '0;
      nclip_q    <= '0;
      x_q        <= '0;
      nn_q       <= '0;
      den_q      <= '0;
      num_q      <= '0;
      mstep_q    <= '0;
      quot_q     <= '0;
      sat_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      out_bin_q  <= '0;
      out_norm_q <= '0;
      out_sat_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      // Output transfer empties the output register unless a result is loaded.
      if (out_vld_q && m_axis_tready && (state_q != ST_OUT)) begin
        out_vld_q <= 1'b0;
      end

      // Read pipeline of the walk.
      rv1_q <= walk_issue;
      rv2_q <= (state_q == ST_PASS2) && rv1_q;
      x_q   <= rdata_q;

      // Advance the walk address.
      if (walk_issue) begin
        if (widx_q == whi) begin
          if (!wseg_q && two_q) begin
            wseg_q <= 1'b1;
            widx_q <= lo1_q;
          end else begin
            wend_q <= 1'b1;
          end
        end else begin
          widx_q <= widx_q + 1'b1;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            rc_q    <= rc_inc;
            last_q  <= s_axis_tlast || (rc_inc >= CNT_W'(MAX_BINS));
            cnt_q   <= '0;
            state_q <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          if (emit_go) begin
            state_q <= ST_SETUP;
          end else begin
            if (last_q) begin
              rc_q   <= '0;
              emit_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end

        // Window edges clipped to the row.
        ST_SETUP: begin
          ls_q    <= (emit_q >= g_c) ? emit_q - g_c : '0;
          le_q    <= (emit_q >= e_c) ? emit_q - e_c : '0;
          rs_q    <= (kpe > {1'b0, len_m1}) ? len_m1 : kpe[CNT_W-1:0];
          re_q    <= (kpg > {1'b0, len_m1}) ? len_m1 : kpg[CNT_W-1:0];
          state_q <= ST_RANGE;
        end

        // Segment choice; the read of bin k is issued here.
        ST_RANGE: begin
          if (ls_q >= le_q) begin
            lo0_q   <= rs_q;
            hi0_q   <= re_q;
            two_q   <= 1'b0;
            empty_q <= rs_q > re_q;
          end else if (rs_q >= re_q) begin
            lo0_q   <= ls_q;
            hi0_q   <= le_q;
            two_q   <= 1'b0;
            empty_q <= 1'b0;
          end else begin
            lo0_q   <= ls_q;
            hi0_q   <= le_q;
            lo1_q   <= rs_q;
            hi1_q   <= re_q;
            two_q   <= 1'b1;
            empty_q <= 1'b0;
          end
          state_q <= ST_KCAP;
        end

        ST_KCAP: begin
          samp_k_q <= rdata_q;
          sum_q    <= '0;
          n_q      <= '0;
          widx_q   <= lo0_q;
          wseg_q   <= 1'b0;
          wend_q   <= 1'b0;
          if (empty_q) begin
            quot_q  <= Q_ONE;
            sat_q   <= 1'b0;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_PASS1;
          end
        end

        // First pass: window sum and count.
        ST_PASS1: begin
          if (rv1_q) begin
            sum_q <= sum_q + SUM_W'(rdata_q);
            n_q   <= n_q + 1'b1;
          end
          if (wend_q && !rv1_q) begin
            state_q <= ST_CLIPMUL;
          end
        end

        ST_CLIPMUL: begin
          state_q <= ST_CLIPCAP;
        end

        ST_CLIPCAP: begin
          clip_s_q <= prod[CLIPS_W-1:0];
          kept_q   <= '0;
          nclip_q  <= '0;
          widx_q   <= lo0_q;
          wseg_q   <= 1'b0;
          wend_q   <= 1'b0;
          state_q  <= ST_PASS2;
        end

        // Second pass: keep values below the clip level, count the rest.
        ST_PASS2: begin
          if (rv2_q) begin
            if (CLIPS_W'({prod[SUM_W-1:0], {CLIP_FRAC_W{1'b0}}}) < clip_s_q) begin
              kept_q <= kept_q + SUM_W'(x_q);
            end else begin
              nclip_q <= nclip_q + 1'b1;
            end
          end
          if (wend_q && !rv1_q && !rv2_q) begin
            mstep_q <= '0;
            state_q <= ST_PRODS;
          end
        end

        // Numerator and denominator through the shared multiplier.
        ST_PRODS: begin
          mstep_q <= mstep_q + 1'b1;
          case (mstep_q)
            3'd1: nn_q  <= prod[NN_W-1:0];
            3'd2: den_q <= DEN_W'(prod[SUM_W+N_W-1:0]);
            3'd3: den_q <= den_q + DEN_W'(prod[SUM_W+N_W-1:0]) + DEN_W'(nn_q);
            3'd4: begin
              num_q   <= {prod[SAMPLE_W+NN_W-1:0], {FRAC_W{1'b0}}};
              state_q <= ST_DIVSTART;
            end
            default: ;
          endcase
        end

        ST_DIVSTART: begin
          state_q <= ST_DIVWAIT;
        end

        ST_DIVWAIT: begin
          if (div_res.done) begin
            quot_q  <= div_res.sat ? Q_MAX : div_res.quot;
            sat_q   <= div_res.sat;
            state_q <= ST_OUT;
          end
        end

        // Hand the result to the output register.
        ST_OUT: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_bin_q  <= emit_q[BIN_W-1:0];
            out_norm_q <= quot_q;
            out_sat_q  <= sat_q;
            out_last_q <= last_q && (emit_q + 1'b1 == rc_q);
            emit_q     <= emit_q + 1'b1;
            cnt_q      <= cnt_q + 1'b1;
            state_q    <= ST_CHECK;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_norm_q, out_bin_q};
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tlast  = out_last_q;

  // The walk pipeline is drained whenever a new bin can be taken.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!rv1_q && !rv2_q))
    else $error("walk pipeline busy while input ready");

  // Emission never runs ahead of the received bins.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= rc_q)
    else $error("emit index beyond received count");

  // At most MAX_RESULTS results per input transfer.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CNT_W'(MAX_RESULTS))
    else $error("too many results for one input");

  // A division finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIVWAIT))
    else $error("divider done outside wait state");

endmodule : tpsw_spectrum_normalizer
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the split-window spectrum normalizer
// Rows of spectrum bins are streamed into the block, and every normalized
// result is compared with a cycle-free prediction of the background estimate.
// Directed rows cover the window limits, the clip extremes, saturation and
// empty windows. Random rows with random register settings follow, and the
// run closes with short rows sent without idling. Both stream sides idle at
// random before that.
// ----------------------------------------------------------------------------
module tb;
  import tpsw_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          QUIET_CYCLES  = 300;
  localparam int          RANDOM_ITEMS  = 150;
  localparam int          REPORT_LIMIT  = 10;
  localparam int          HOLD_CYCLES   = 600;
  // Register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // One normalized bin as the block should deliver it.
  typedef struct packed {
    logic [BIN_W-1:0]    bin_index;
    logic [SAMPLE_W-1:0] ratio;
    logic                sat;
    logic                row_last;
  } norm_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  // Predicted block state.
  logic [SAMPLE_W-1:0] bin_ring [RING_DEPTH];
  int                  rcv_count;
  int                  emit_idx;
  logic [HW_W-1:0]     outer_cfg;
  logic [HW_W-1:0]     gap_cfg;
  logic [CLIP_W-1:0]   clip_cfg;
  norm_result_t        expected_bins [$];

  // Run bookkeeping.
  bit          src_idling;
  bit          sink_idling;
  int          sink_hold_req;
  int          mismatches;
  int          results_checked;
  int          items_sent;
  int          random_items;
  int          rows_done;
  int          cfg_writes;
  int unsigned cycle_count;
  norm_result_t want;

  tpsw_spectrum_normalizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_bins.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint unsigned ring_word(input int idx);
    return longint'(bin_ring[idx % RING_DEPTH]);
  endfunction

  // Outer half width as the block uses it: zero counts as one bin.
  function automatic int eff_outer();
    if (outer_cfg == 0) return 1;
    if (outer_cfg > MAX_HALF_WIDTH) return MAX_HALF_WIDTH;
    return int'(outer_cfg);
  endfunction

  // Background estimate and ratio for bin k of a row holding len bins so far.
  function automatic norm_result_t predict_bin(input int k, input int len);
    int g, e, ls, le, rs, re, nseg, seg, i;
    int seg_lo [2];
    int seg_hi [2];
    longint unsigned n, sum, kept, nclip, x, num, den, q;
    norm_result_t r;
    g = eff_outer();
    e = (gap_cfg > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : int'(gap_cfg);
    ls = (k - g < 0) ? 0 : k - g;
    le = (k - e < 0) ? 0 : k - e;
    rs = (k + e > len - 1) ? len - 1 : k + e;
    re = (k + g > len - 1) ? len - 1 : k + g;
    // Left dropped if ls >= le, else right if rs >= re; zero gap may count k twice.
    if (ls >= le) begin
      seg_lo[0] = rs;
      seg_hi[0] = re;
      nseg = 1;
    end else if (rs >= re) begin
      seg_lo[0] = ls;
      seg_hi[0] = le;
      nseg = 1;
    end else begin
      seg_lo[0] = ls;
      seg_hi[0] = le;
      seg_lo[1] = rs;
      seg_hi[1] = re;
      nseg = 2;
    end
    n = 0;
    sum = 0;
    kept = 0;
    nclip = 0;
    for (seg = 0; seg < nseg; seg++) begin
      for (i = seg_lo[seg]; i <= seg_hi[seg]; i++) begin
        sum += ring_word(i);
        n++;
      end
    end
    r.bin_index = k[BIN_W-1:0];
    r.ratio     = Q_ONE;
    r.sat       = 1'b0;
    r.row_last  = 1'b0;
    if (n != 0) begin
      // Second pass: values at or above the clip level are replaced by the mean.
      for (seg = 0; seg < nseg; seg++) begin
        for (i = seg_lo[seg]; i <= seg_hi[seg]; i++) begin
          x = ring_word(i);
          if (x * n * 4096 < longint'(clip_cfg) * sum) kept += x;
          else nclip++;
        end
      end
      num = ring_word(k) * 256 * n * n;
      den = kept * n + nclip * sum + n * n;
      q = num / den;
      if (q > 65535) begin
        r.ratio = '1;
        r.sat   = 1'b1;
      end else begin
        r.ratio = q[SAMPLE_W-1:0];
      end
    end
    return r;
  endfunction

  // Takes one accepted bin and queues every result it releases.
  function automatic void absorb_bin(input logic [SAMPLE_W-1:0] smp, input logic tl);
    int g, emitted;
    bit row_end;
    norm_result_t r;
    g = eff_outer();
    bin_ring[rcv_count % RING_DEPTH] = smp;
    rcv_count++;
    row_end = tl || rcv_count >= MAX_BINS;
    emitted = 0;
    while (emitted < MAX_RESULTS && emit_idx < rcv_count &&
           (row_end || rcv_count - emit_idx > g)) begin
      r = predict_bin(emit_idx, rcv_count);
      r.row_last = row_end && (emit_idx + 1 == rcv_count);
      expected_bins.insert(expected_bins.size(), r);
      emit_idx++;
      emitted++;
    end
    if (row_end) begin
      rcv_count = 0;
      emit_idx = 0;
      rows_done++;
    end
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_OUTER: outer_cfg = val[HW_W-1:0];
      CFG_GAP:   gap_cfg = val[HW_W-1:0];
      CFG_CLIP:  clip_cfg = val[CLIP_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_bins.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("[%0t] result with nothing expected: tdata %h tuser %b tlast %b",
                   $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_bins.pop_front();
        if (m_axis_tdata[BIN_W-1:0] !== want.bin_index ||
            m_axis_tdata[BIN_W +: SAMPLE_W] !== want.ratio ||
            m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0 ||
            m_axis_tuser !== want.sat || m_axis_tlast !== want.row_last) begin
          if (mismatches < REPORT_LIMIT)
            $display({"[%0t] mismatch: expected bin %0d ratio %0d sat %b last %b,",
                      " got bin %0d ratio %0d pad %h sat %b last %b"},
                     $realtime, want.bin_index, want.ratio, want.sat, want.row_last,
                     m_axis_tdata[BIN_W-1:0], m_axis_tdata[BIN_W +: SAMPLE_W],
                     m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W], m_axis_tuser,
                     m_axis_tlast);
          mismatches++;
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, and a long hold when one is requested
  // ---------------------------------------------------------------------------

  initial begin : sink_ctrl
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req != 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void set_idling(input bit on);
    src_idling = on;
    sink_idling = on;
  endfunction

  // Offers one bin, with an optional random gap, and waits for its transfer.
  // The valid stays high afterwards so that back-to-back bins need no gap.
  task automatic send_bin(input logic [SAMPLE_W-1:0] smp, input logic tl);
    int gap;
    @(negedge clk_i);
    if (src_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= tl;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_bin(smp, tl);
    items_sent++;
  endtask

  // Stops offering, waits for every expected result and lets the block finish.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_cfg(idx, val);
    cfg_writes++;
  endtask

  // Bin level around a row base, with zeros, full-scale values and spikes.
  function automatic logic [SAMPLE_W-1:0] row_sample(input int base);
    int v;
    case ($urandom_range(0, 15))
      0:       v = 0;
      1:       v = 65535;
      2, 3:    v = $urandom_range(0, 65535);
      default: v = base + $urandom_range(0, base / 2 + 8);
    endcase
    if (v > 65535) v = 65535;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_row(input int len, input int base);
    int i;
    for (i = 0; i < len; i++) send_bin(row_sample(base), i == len - 1);
  endtask

  // Outer width with the out-of-range codes included, upper write bits random.
  function automatic logic [CFG_DATA_W-1:0] random_outer();
    int g;
    case ($urandom_range(0, 9))
      0:       g = 0;
      1:       g = 63;
      2:       g = 1;
      3:       g = MAX_HALF_WIDTH;
      default: g = $urandom_range(1, MAX_HALF_WIDTH);
    endcase
    return {10'($urandom_range(0, 1023)), g[HW_W-1:0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of all registers, extreme samples, a row shorter than G.
  task automatic test_reset_defaults();
    send_bin(16'h0000, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h5555, 1'b0);
    send_bin(16'hAAAA, 1'b0);
    send_bin(16'h0001, 1'b0);
    send_bin(16'h8000, 1'b1);
    send_bin(16'h1234, 1'b1);
  endtask

  // A zero gap counts the center bin twice where both sides remain.
  task automatic test_gap_zero();
    write_cfg(CFG_OUTER, 16'd3);
    write_cfg(CFG_GAP, 16'd0);
    send_row(7, 500);
  endtask

  // A gap wider than the outer extent leaves inner bins without any window.
  task automatic test_empty_window();
    write_cfg(CFG_OUTER, 16'd1);
    write_cfg(CFG_GAP, 16'd5);
    send_row(10, 300);
  endtask

  // Outer width of zero and codes above the maximum for both widths.
  task automatic test_window_limits();
    write_cfg(CFG_OUTER, 16'd0);
    write_cfg(CFG_GAP, 16'd63);
    send_row(5, 1000);
    write_cfg(CFG_OUTER, 16'hFFFF);
    write_cfg(CFG_GAP, 16'd0);
    send_row(6, 1000);
  endtask

  // Clip ratio of zero clips everything; the largest clips almost nothing.
  task automatic test_clip_extremes();
    write_cfg(CFG_OUTER, 16'd2);
    write_cfg(CFG_GAP, 16'd1);
    write_cfg(CFG_CLIP, 16'd0);
    send_row(6, 200);
    write_cfg(CFG_CLIP, 16'hFFFF);
    send_row(6, 200);
    write_cfg(CFG_CLIP, 16'd4096);
    send_bin(16'd100, 1'b0);
    send_bin(16'd100, 1'b0);
    send_bin(16'd40000, 1'b0);
    send_bin(16'd100, 1'b0);
    send_bin(16'd101, 1'b1);
  endtask

  // Full-scale bins over a zero or tiny background saturate the ratio.
  task automatic test_saturation();
    write_cfg(CFG_CLIP, 16'd6144);
    send_bin(16'd0, 1'b0);
    send_bin(16'd0, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'd0, 1'b0);
    send_bin(16'd0, 1'b1);
    send_bin(16'd1, 1'b0);
    send_bin(16'd1, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'd1, 1'b0);
    send_bin(16'd1, 1'b1);
  endtask

  // A write to an undecoded index changes nothing.
  task automatic test_unused_index();
    write_cfg(CFG_SPARE, 16'hFFFF);
    send_row(5, 50);
  endtask

  // The widest window flushes the most results on the final bin.
  task automatic test_longest_flush();
    write_cfg(CFG_OUTER, 16'd32);
    write_cfg(CFG_GAP, 16'd2);
    send_row(34, 2000);
  endtask

  // Narrowing the window mid-row releases a burst; widening it holds results.
  task automatic test_window_change_midrow();
    int i;
    write_cfg(CFG_GAP, 16'd1);
    for (i = 0; i < 33; i++) send_bin(row_sample(800), 1'b0);
    write_cfg(CFG_OUTER, 16'd1);
    send_bin(row_sample(800), 1'b0);
    send_bin(row_sample(800), 1'b0);
    write_cfg(CFG_OUTER, 16'd20);
    send_row(5, 800);
  endtask

  // The output side holds off for a long time while bins keep coming.
  task automatic test_backpressure();
    write_cfg(CFG_OUTER, 16'd4);
    write_cfg(CFG_GAP, 16'd1);
    set_idling(1'b0);
    send_bin(row_sample(3000), 1'b0);
    sink_hold_req = HOLD_CYCLES;
    send_row(40, 3000);
    set_idling(1'b1);
  endtask

  // Random rows under random settings, some with a window change mid-row.
  task automatic test_random_rows();
    int len, base, cut, i, c;
    while (random_items < RANDOM_ITEMS) begin
      set_idling($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        write_cfg(CFG_OUTER, random_outer());
        case ($urandom_range(0, 7))
          0:       c = 0;
          1:       c = MAX_HALF_WIDTH;
          2:       c = 63;
          default: c = $urandom_range(0, MAX_HALF_WIDTH);
        endcase
        write_cfg(CFG_GAP, {10'($urandom_range(0, 1023)), c[HW_W-1:0]});
        case ($urandom_range(0, 7))
          0:       c = 0;
          1:       c = 4096;
          2:       c = 65535;
          3:       c = $urandom_range(0, 4095);
          default: c = $urandom_range(4096, 65535);
        endcase
        write_cfg(CFG_CLIP, c[CFG_DATA_W-1:0]);
      end
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = $urandom_range(100, 200);
        default: len = $urandom_range(2, 60);
      endcase
      // Keep the total close to the planned number of random bins.
      if (len > RANDOM_ITEMS - random_items) len = RANDOM_ITEMS - random_items;
      case ($urandom_range(0, 3))
        0:       base = $urandom_range(0, 20);
        1:       base = $urandom_range(0, 40000);
        default: base = $urandom_range(500, 3000);
      endcase
      cut = (len > 2 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : -1;
      for (i = 0; i < len; i++) begin
        if (i == cut) write_cfg(CFG_OUTER, random_outer());
        send_bin(row_sample(base), i == len - 1);
        random_items++;
      end
    end
  endtask

  // Closing rows with both stream sides always ready; no idling in this part.
  task automatic test_closing_rows();
    set_idling(1'b0);
    write_cfg(CFG_OUTER, 16'd3);
    write_cfg(CFG_GAP, 16'd1);
    write_cfg(CFG_CLIP, 16'($urandom_range(4096, 65535)));
    send_row(12, 100);
    send_row(8, 2500);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    sink_hold_req = 0;
    rcv_count     = 0;
    emit_idx      = 0;
    outer_cfg     = OUTER_RST;
    gap_cfg       = GAP_RST;
    clip_cfg      = CLIP_RST;
    set_idling(1'b1);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_gap_zero();
    test_empty_window();
    test_window_limits();
    test_clip_extremes();
    test_saturation();
    test_unused_index();
    test_longest_flush();
    test_window_change_midrow();
    test_backpressure();
    test_random_rows();
    test_closing_rows();

    settle();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    $display("Sent %0d bins (%0d random) in %0d rows; checked %0d results; %0d register writes.",
             items_sent, random_items, rows_done, results_checked, cfg_writes);
    $display({"Windows from 1 to 32 bins and codes beyond, gaps 0 to beyond the limit,",
              " clip ratios 0 to 65535, saturation, empty windows, back-pressure."});
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tpsw_pkg.sv
hdl/tpsw_mul.sv
hdl/tpsw_div.sv
hdl/tpsw_spectrum_normalizer.sv
tb/tb.sv
